// File: rtl/size_class_pool_allocator_macros.svh
// assertion macros for the size class pool allocator
`ifndef SIZE_CLASS_POOL_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_MACROS_SVH

// property that must hold on every clock outside reset
`define SCPA_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("allocator assertion failed");

// antecedent implies consequent in the same cycle
`define SCPA_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

`endif

// File: rtl/scpa_pkg.sv
// shared types and constants of the size class pool allocator
package scpa_pkg;

   localparam int POOL_BYTES  = 65536;
   localparam int NUM_CLASSES = 7;
   localparam int GRAIN_SHIFT = 3;
   localparam int SLOTS       = POOL_BYTES >> GRAIN_SHIFT;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int HEAD_W      = SLOT_W + 1;
   localparam int LIM_W       = $clog2(POOL_BYTES) + 1;
   localparam int CLS_W       = 3;
   localparam int ADDR_W      = 16;
   localparam int SIZE_W      = 24;
   localparam int TOT_W       = 32;
   localparam int CSR_W       = 17;
   localparam int BIG_LIMIT   = 512;
   localparam int BLOCK_MIN   = 8;
   localparam int CHUNK_RESET = 4096;

   typedef enum logic [1:0] {
      OPC_ALLOC  = 2'd0,
      OPC_FREE   = 2'd1,
      OPC_RESIZE = 2'd2,
      OPC_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STS_NEW  = 3'd0,
      STS_KEEP = 3'd1,
      STS_NULL = 3'd2,
      STS_BIG  = 3'd3,
      STS_FULL = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      K_NONE, K_ALLOC_BIG, K_ALLOC, K_FREE_BIG, K_FREE, K_RS_BIG,
      K_RS_IN, K_RS_OUT, K_RS_KEEP, K_RS_MOVE
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [ADDR_W-1:0]       addr;
      logic [SIZE_W-1:0]       osz;
      logic [SIZE_W-1:0]       nsz;
      logic [SIZE_W-1:0]       copy;
      logic [CLS_W-1:0]        oc;
      logic [CLS_W-1:0]        nc;
   } req_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [HEAD_W-1:0] wr_data;
   } link_req_type;

   function automatic logic [CLS_W-1:0] class_of(input logic [SIZE_W-1:0] sz);
      logic [CLS_W-1:0] c;
      if (sz > 24'd256)      c = 3'd6;
      else if (sz > 24'd128) c = 3'd5;
      else if (sz > 24'd64)  c = 3'd4;
      else if (sz > 24'd32)  c = 3'd3;
      else if (sz > 24'd16)  c = 3'd2;
      else if (sz > 24'd8)   c = 3'd1;
      else                   c = 3'd0;
      return c;
   endfunction

endpackage

// File: rtl/scpa_ram.sv
// generic single write, single read ram with registered read
module scpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/scpa_front.sv
// front end: decodes a request word into a classified job
module scpa_front (
   input  logic [1:0]               req_op,
   input  logic [15:0]              req_block_address,
   input  logic [23:0]              req_old_size,
   input  logic [23:0]              req_new_size,
   output scpa_pkg::req_type        job
);
   import scpa_pkg::*;

   logic obig, nbig, nzero;
   logic [CLS_W-1:0] oc, nc;

   always_comb begin
      obig  = req_old_size > SIZE_W'(BIG_LIMIT);
      nbig  = req_new_size > SIZE_W'(BIG_LIMIT);
      nzero = req_new_size == '0;
      oc    = class_of(req_old_size);
      nc    = class_of(req_new_size);
      job.addr = req_block_address;
      job.osz  = req_old_size;
      job.nsz  = req_new_size;
      job.oc   = oc;
      job.nc   = nc;
      job.copy = '0;
      job.kind = K_NONE;
      unique case (opcode_type'(req_op))
         OPC_ALLOC: begin
            if (nbig) job.kind = K_ALLOC_BIG;
            else if (!nzero) job.kind = K_ALLOC;
         end
         OPC_FREE: job.kind = obig ? K_FREE_BIG : K_FREE;
         OPC_RESIZE: begin
            if (nzero) job.kind = obig ? K_FREE_BIG : K_FREE;
            else if (obig && nbig) job.kind = K_RS_BIG;
            else if (obig) begin
               job.kind = K_RS_IN;
               job.copy = req_new_size;
            end else if (nbig) begin
               job.kind = K_RS_OUT;
               job.copy = req_old_size;
            end else if (oc == nc) job.kind = K_RS_KEEP;
            else begin
               job.kind = K_RS_MOVE;
               job.copy = (req_old_size < req_new_size) ? req_old_size : req_new_size;
            end
         end
         default: job.kind = K_NONE;
      endcase
   end
endmodule

// File: rtl/scpa_queue.sv
// two entry job queue between front and back
module scpa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scpa_pkg::req_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output scpa_pkg::req_type head_job
);
   import scpa_pkg::*;

   req_type    slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign head_job = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= push_job;
   end
endmodule

// File: rtl/scpa_back.sv
// back end: free lists, bump pointer, chunks, totals and the result register
`include "size_class_pool_allocator_macros.svh"
module scpa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [16:0]            csr_wdata,
   input  logic                   job_empty,
   input  scpa_pkg::req_type      job,
   output logic                   job_pop,
   output scpa_pkg::link_req_type link,
   input  logic [scpa_pkg::HEAD_W-1:0] link_rd_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_result_address,
   output logic [2:0]             rsp_status,
   output logic [23:0]            rsp_copy_bytes,
   output logic                   rsp_release_old_small,
   output logic [31:0]            rsp_memory_total,
   output logic [31:0]            rsp_big_total,
   output logic [7:0]             rsp_chunks_open
);
   import scpa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type         st_ff, st_in;
   req_type           cur_ff;
   logic [HEAD_W-1:0] heads_ff [NUM_CLASSES];
   logic [HEAD_W-1:0] heads_in [NUM_CLASSES];
   logic [CSR_W-1:0]  csize_ff;
   logic [LIM_W-1:0]  bump_ff, bump_in, limit_ff, limit_in;
   logic [7:0]        count_ff, count_in;
   logic [TOT_W-1:0]  reqb_ff, reqb_in, outb_ff, outb_in;

   logic              rv_ff;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   status_type        sts_ff, sts_in;
   logic [SIZE_W-1:0] copy_ff, copy_in;
   logic              rel_ff, rel_in;

   logic              slot_free, start;
   logic [HEAD_W-1:0] hd;
   logic [LIM_W-1:0]  need, csize_l;
   logic [LIM_W:0]    next_end;
   logic              room, fits, ok;
   logic [TOT_W-1:0]  osz_w, nsz_w;
   logic              do_grant, do_rel;
   logic [ADDR_W-1:0] gaddr;
   logic [SLOT_W-1:0] rel_slot;

   assign slot_free = !rv_ff || rsp_ready;
   assign start     = (st_ff == ST_IDLE) && !job_empty && slot_free;
   assign job_pop   = start;

   // grant check on the latched job
   always_comb begin
      hd       = heads_ff[cur_ff.nc];
      csize_l  = LIM_W'(csize_ff);
      need     = LIM_W'(BLOCK_MIN) << cur_ff.nc;
      next_end = {1'b0, limit_ff} + {1'b0, csize_l};
      room     = (limit_ff - bump_ff) >= need;
      fits     = (csize_l >= need) && (next_end <= (LIM_W+1)'(POOL_BYTES));
      ok       = (hd != '0) || room || fits;
      osz_w    = TOT_W'(cur_ff.osz);
      nsz_w    = TOT_W'(cur_ff.nsz);
      rel_slot = SLOT_W'(cur_ff.addr >> GRAIN_SHIFT);
   end

   always_comb begin
      st_in    = st_ff;
      heads_in = heads_ff;
      bump_in  = bump_ff;
      limit_in = limit_ff;
      count_in = count_ff;
      reqb_in  = reqb_ff;
      outb_in  = outb_ff;
      raddr_in = '0;
      sts_in   = STS_NULL;
      copy_in  = '0;
      rel_in   = 1'b0;
      do_grant = 1'b0;
      do_rel   = 1'b0;
      gaddr    = '0;
      link.rd_en   = start;
      link.rd_addr = SLOT_W'(heads_ff[job.nc] - HEAD_W'(1));
      link.wr_en   = 1'b0;
      link.wr_addr = rel_slot;
      link.wr_data = heads_ff[cur_ff.oc];
      unique case (st_ff)
         ST_IDLE: if (start) st_in = ST_EXEC;
         ST_EXEC: begin
            st_in = ST_IDLE;
            case (cur_ff.kind)
               K_ALLOC_BIG: begin
                  reqb_in = reqb_ff + nsz_w;
                  outb_in = outb_ff + nsz_w;
                  sts_in  = STS_BIG;
               end
               K_ALLOC: begin
                  if (ok) begin
                     reqb_in  = reqb_ff + nsz_w;
                     do_grant = 1'b1;
                  end else sts_in = STS_FULL;
               end
               K_FREE_BIG: begin
                  reqb_in = reqb_ff - osz_w;
                  outb_in = outb_ff - osz_w;
               end
               K_FREE: begin
                  reqb_in = reqb_ff - osz_w;
                  do_rel  = 1'b1;
               end
               K_RS_BIG: begin
                  reqb_in = reqb_ff - osz_w + nsz_w;
                  outb_in = outb_ff - osz_w + nsz_w;
                  sts_in  = STS_BIG;
               end
               K_RS_IN: begin
                  if (ok) begin
                     reqb_in  = reqb_ff - osz_w + nsz_w;
                     outb_in  = outb_ff - osz_w;
                     do_grant = 1'b1;
                     copy_in  = cur_ff.copy;
                  end else sts_in = STS_FULL;
               end
               K_RS_OUT: begin
                  reqb_in = reqb_ff - osz_w + nsz_w;
                  outb_in = outb_ff + nsz_w;
                  do_rel  = 1'b1;
                  copy_in = cur_ff.copy;
                  sts_in  = STS_BIG;
               end
               K_RS_KEEP: begin
                  reqb_in  = reqb_ff - osz_w + nsz_w;
                  raddr_in = cur_ff.addr;
                  sts_in   = STS_KEEP;
               end
               K_RS_MOVE: begin
                  if (ok) begin
                     reqb_in  = reqb_ff - osz_w + nsz_w;
                     do_grant = 1'b1;
                     do_rel   = 1'b1;
                     copy_in  = cur_ff.copy;
                  end else sts_in = STS_FULL;
               end
               default: sts_in = STS_NULL;
            endcase
            // grant: pop the free list, else bump, else open a chunk
            if (do_grant) begin
               sts_in = STS_NEW;
               if (hd != '0) begin
                  heads_in[cur_ff.nc] = link_rd_data;
                  gaddr = ADDR_W'(SLOT_W'(hd - HEAD_W'(1))) << GRAIN_SHIFT;
               end else if (room) begin
                  gaddr   = ADDR_W'(bump_ff);
                  bump_in = bump_ff + need;
               end else begin
                  gaddr    = ADDR_W'(limit_ff);
                  bump_in  = limit_ff + need;
                  limit_in = LIM_W'(next_end);
                  count_in = count_ff + 8'd1;
               end
               raddr_in = gaddr;
            end
            // release: push the old block onto its list
            if (do_rel) begin
               rel_in      = 1'b1;
               link.wr_en  = 1'b1;
               heads_in[cur_ff.oc] = HEAD_W'(rel_slot) + HEAD_W'(1);
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         for (int i = 0; i < NUM_CLASSES; i++) heads_ff[i] <= '0;
         csize_ff <= CSR_W'(CHUNK_RESET);
         bump_ff  <= '0;
         limit_ff <= LIM_W'(CHUNK_RESET);
         count_ff <= 8'd1;
         reqb_ff  <= '0;
         outb_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         st_ff    <= st_in;
         heads_ff <= heads_in;
         bump_ff  <= bump_in;
         limit_ff <= limit_in;
         count_ff <= count_in;
         reqb_ff  <= reqb_in;
         outb_ff  <= outb_in;
         if (csr_we) csize_ff <= {csr_wdata[CSR_W-1:3], 3'b000};
         if (st_ff == ST_EXEC) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
      if (start) cur_ff <= job;
      if (st_ff == ST_EXEC) begin
         raddr_ff <= raddr_in;
         sts_ff   <= sts_in;
         copy_ff  <= copy_in;
         rel_ff   <= rel_in;
      end
   end

   assign rsp_valid             = rv_ff;
   assign rsp_result_address    = raddr_ff;
   assign rsp_status            = sts_ff;
   assign rsp_copy_bytes        = copy_ff;
   assign rsp_release_old_small = rel_ff;
   assign rsp_memory_total      = reqb_ff;
   assign rsp_big_total         = outb_ff;
   assign rsp_chunks_open       = count_ff;

   `SCPA_ALWAYS(a_state_onehot, $onehot(st_ff))
   `SCPA_IMPLY(a_exec_slot_empty, st_ff == ST_EXEC, !rv_ff)
   `SCPA_ALWAYS(a_bump_in_chunk, bump_ff <= limit_ff)
   `SCPA_ALWAYS(a_limit_in_pool, limit_ff <= LIM_W'(POOL_BYTES))
endmodule

// File: rtl/size_class_pool_allocator.sv
// top level of the size class pool allocator
// Seven power-of-two size classes (8 to 512 bytes) served from per-class LIFO
// free lists and a bump pointer inside chunks whose payload size the csr register
// sets; larger requests are only counted for an outside allocator. In the back end
// each request word first issues the free-list link read and then applies the
// result, since a pop needs the link memory's registered read data before the
// class head can move. A two-word queue after the decoder lets request words be
// accepted while the back end works; once two words wait behind a busy back end
// or a stalled response, req_ready drops until the back end takes one. The back
// end starts a word only when the response register is free or being read, so
// responses come out in request order, one per request. The link memory has no
// clearing pass; only entries written by a free are ever used. csr_ready is
// always high.
module size_class_pool_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_block_address,
   input  logic [23:0] req_old_size,
   input  logic [23:0] req_new_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_address,
   output logic [2:0]  rsp_status,
   output logic [23:0] rsp_copy_bytes,
   output logic        rsp_release_old_small,
   output logic [31:0] rsp_memory_total,
   output logic [31:0] rsp_big_total,
   output logic [7:0]  rsp_chunks_open,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_wdata
);
   import scpa_pkg::*;

   req_type           dec_job, q_job;
   logic              q_full, q_empty, q_pop;
   link_req_type      link;
   logic [HEAD_W-1:0] link_rd_data;

   // config register is always writable
   assign csr_ready = 1'b1;
   assign req_ready = !q_full;

   // decode and classify the incoming word
   scpa_front u_front (
      .req_op            (req_op),
      .req_block_address (req_block_address),
      .req_old_size      (req_old_size),
      .req_new_size      (req_new_size),
      .job               (dec_job)
   );

   // decouples acceptance from execution
   scpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid && !q_full),
      .push_job (dec_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (q_job)
   );

   // free lists, chunks and totals
   scpa_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_valid),
      .csr_wdata             (csr_wdata),
      .job_empty             (q_empty),
      .job                   (q_job),
      .job_pop               (q_pop),
      .link                  (link),
      .link_rd_data          (link_rd_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_address    (rsp_result_address),
      .rsp_status            (rsp_status),
      .rsp_copy_bytes        (rsp_copy_bytes),
      .rsp_release_old_small (rsp_release_old_small),
      .rsp_memory_total      (rsp_memory_total),
      .rsp_big_total         (rsp_big_total),
      .rsp_chunks_open       (rsp_chunks_open)
   );

   // next-slot links of all free lists, one entry per 8-byte slot
   scpa_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link.wr_en),
      .wr_addr (link.wr_addr),
      .wr_data (link.wr_data),
      .rd_en   (link.rd_en),
      .rd_addr (link.rd_addr),
      .rd_data (link_rd_data)
   );
endmodule
